>>> rtl/swcc_pkg.sv
// Shared types and constants for the sensor word CRC checker.
// No dependencies; used by the top level and swcc_framer, not by swcc_crc8.
package swcc_pkg;

  // Register reset values
  localparam logic [7:0] POLY_RESET  = 8'h31;
  localparam logic [7:0] START_RESET = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_POLY  = 1'b0;
  localparam logic CFG_START = 1'b1;

  // Position of a byte within its triple
  localparam logic [1:0] PHASE_HIGH   = 2'd0;
  localparam logic [1:0] PHASE_LOW    = 2'd1;
  localparam logic [1:0] PHASE_CRC    = 2'd2;
  localparam logic [1:0] PHASE_UNUSED = 2'd3;

  // Word position saturates here
  localparam logic [2:0] WORD_COUNT_MAX = 3'd7;

  // CRC settings seen by the framer
  typedef struct packed {
    logic [7:0] crc_polynomial;
    logic [7:0] crc_start_value;
  } cfg_t;

  // One checked word
  typedef struct packed {
    logic [15:0] word_value;
    logic        crc_match;
    logic [2:0]  word_number;
  } result_t;

  // Framer state exported for checking
  typedef struct packed {
    logic [1:0] byte_phase;
    logic [2:0] word_count;
  } status_t;

endpackage

>>> rtl/sensor_word_crc_checker_top.sv
// Top level of the sensor word CRC checker: config registers, request register, framer.
// Depends on swcc_pkg and swcc_framer.
// A CRC byte passes the request register first; its result then goes to the output register.
// One byte per cycle unless held back; the framer's unrolled byte CRC is the only logic stage.
// A full output register that is not taken holds back only the CRC byte of the next triple.
// Reset: synchronous; polynomial to 0x31, start value to 0xFF, grouping and count to zero.
module sensor_word_crc_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        response_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] word_value,
  output logic        crc_match,
  output logic [2:0]  word_number
);

  swcc_pkg::cfg_t    cfg;
  swcc_pkg::result_t result;
  swcc_pkg::status_t status;

  logic       req_valid;
  logic [7:0] req_byte;
  logic       req_start;
  logic       req_take;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_polynomial  <= swcc_pkg::POLY_RESET;
      cfg.crc_start_value <= swcc_pkg::START_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        swcc_pkg::CFG_POLY:  cfg.crc_polynomial  <= cfg_data;
        swcc_pkg::CFG_START: cfg.crc_start_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request; accept a new one as the held one drains
  assign in_ready = !req_valid || req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_byte  <= rx_byte;
      req_start <= response_start;
    end
  end

  swcc_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_byte  (req_byte),
    .req_start (req_start),
    .req_take  (req_take),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .status    (status)
  );

  assign word_value  = result.word_value;
  assign crc_match   = result.crc_match;
  assign word_number = result.word_number;

  // Grouping never reaches the unused phase
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    status.byte_phase != swcc_pkg::PHASE_UNUSED)
    else $error("byte phase reached unused code");

  // A request is never overwritten while still held
  a_req_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_valid) |-> req_take)
    else $error("held request overwritten");

  // Reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A reported word number never runs ahead of the count that follows it
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (req_take && !req_start && status.byte_phase == swcc_pkg::PHASE_CRC
     && status.word_count != swcc_pkg::WORD_COUNT_MAX)
    |=> (out_valid && word_number + 3'd1 == status.word_count))
    else $error("word count out of step with result");

endmodule

>>> rtl/swcc_crc8.sv
// Byte-wide MSB-first CRC-8 update, unrolled over the eight bits.
// Depends on nothing; instanced by swcc_framer.
module swcc_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  input  logic [7:0] polynomial,
  output logic [7:0] crc_out
);

  // Shift the eight bits through, folding in the polynomial on a carry
  always_comb begin
    logic [7:0] v;
    v = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ polynomial;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc_out = v;
  end

endmodule

>>> rtl/swcc_framer.sv
// Triple grouping, running CRC, word count and the result register.
// Depends on swcc_pkg and swcc_crc8.
module swcc_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [7:0]           req_byte,
  input  logic                 req_start,
  output logic                 req_take,
  input  swcc_pkg::cfg_t       cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output swcc_pkg::result_t    result,
  output swcc_pkg::status_t    status
);

  logic [1:0] byte_phase;
  logic [7:0] high_byte_hold;
  logic [7:0] low_byte_hold;
  logic [7:0] running_crc;
  logic [2:0] word_count;

  logic [1:0] phase_eff;
  logic [2:0] count_eff;
  logic [7:0] crc_eff;
  logic [7:0] crc_seed;
  logic [7:0] crc_new;
  logic       emits;

  // A start mark restarts grouping before the byte is looked at
  assign phase_eff = req_start ? swcc_pkg::PHASE_HIGH : byte_phase;
  assign count_eff = req_start ? 3'd0 : word_count;
  assign crc_eff   = req_start ? cfg.crc_start_value : running_crc;
  assign crc_seed  = (phase_eff == swcc_pkg::PHASE_LOW) ? crc_eff : cfg.crc_start_value;
  assign emits     = (phase_eff == swcc_pkg::PHASE_CRC);

  swcc_crc8 u_crc8 (
    .crc_in     (crc_seed),
    .data       (req_byte),
    .polynomial (cfg.crc_polynomial),
    .crc_out    (crc_new)
  );

  // Consume the request unless its result would overwrite a waiting one
  assign req_take = req_valid && (!emits || !out_valid || out_ready);

  // Advance the grouping state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= swcc_pkg::PHASE_HIGH;
      high_byte_hold <= 8'h00;
      low_byte_hold  <= 8'h00;
      running_crc    <= swcc_pkg::START_RESET;
      word_count     <= 3'd0;
    end else if (req_take) begin
      case (phase_eff)
        swcc_pkg::PHASE_LOW: begin
          low_byte_hold <= req_byte;
          running_crc   <= crc_new;
          byte_phase    <= swcc_pkg::PHASE_CRC;
        end
        swcc_pkg::PHASE_CRC: begin
          if (count_eff < swcc_pkg::WORD_COUNT_MAX) begin
            word_count <= count_eff + 3'd1;
          end
          running_crc <= cfg.crc_start_value;
          byte_phase  <= swcc_pkg::PHASE_HIGH;
        end
        default: begin
          high_byte_hold <= req_byte;
          running_crc    <= crc_new;
          word_count     <= count_eff;
          byte_phase     <= swcc_pkg::PHASE_LOW;
        end
      endcase
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_take && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && emits) begin
      result.word_value  <= {high_byte_hold, low_byte_hold};
      result.crc_match   <= (req_byte == crc_eff);
      result.word_number <= count_eff;
    end
  end

  assign status.byte_phase = byte_phase;
  assign status.word_count = word_count;

endmodule

>>> tb/swcc_word_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the sensor word CRC checker: tracks config writes, predicts each word.
// Depends on swcc_pkg; instantiated beside the block by sensor_word_crc_checker_top_test.
module swcc_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        response_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] word_value,
  input  logic        crc_match,
  input  logic [2:0]  word_number,
  output int          word_errors,
  output int          words_outstanding
);

  // Position of a byte within its triple
  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_CRC  = 2'd2;

  swcc_pkg::cfg_t    crc_cfg;
  logic [1:0]        triple_pos;
  logic [7:0]        high_data;
  logic [7:0]        low_data;
  logic [7:0]        crc_acc;
  logic [2:0]        word_index;
  swcc_pkg::result_t expected_words [$];

  // One byte through the MSB-first CRC-8 with the current polynomial
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++)
      v = v[7] ? ((v << 1) ^ poly) : (v << 1);
    return v;
  endfunction

  // Advance the framing model by one accepted byte
  task automatic predict_byte(input logic [7:0] data, input logic start);
    swcc_pkg::result_t w;
    if (start) begin
      triple_pos = PH_HIGH;
      word_index = '0;
      crc_acc    = crc_cfg.crc_start_value;
    end
    case (triple_pos)
      PH_LOW: begin
        low_data   = data;
        crc_acc    = crc8_update(crc_acc, data, crc_cfg.crc_polynomial);
        triple_pos = PH_CRC;
      end
      PH_CRC: begin
        w.word_value  = {high_data, low_data};
        w.crc_match   = (data == crc_acc);
        w.word_number = word_index;
        expected_words.push_back(w);
        if (word_index < swcc_pkg::WORD_COUNT_MAX) word_index = word_index + 3'd1;
        crc_acc    = crc_cfg.crc_start_value;
        triple_pos = PH_HIGH;
      end
      default: begin
        high_data  = data;
        crc_acc    = crc8_update(crc_cfg.crc_start_value, data, crc_cfg.crc_polynomial);
        triple_pos = PH_LOW;
      end
    endcase
  endtask

  // Compare one delivered word with the oldest prediction
  task automatic check_word();
    swcc_pkg::result_t want;
    if (expected_words.size() == 0) begin
      word_errors++;
      if (word_errors <= 10)
        $display("ERROR: unexpected word %h match %b number %0d",
                 word_value, crc_match, word_number);
    end else begin
      want = expected_words.pop_front();
      if (want.word_value !== word_value || want.crc_match !== crc_match ||
          want.word_number !== word_number) begin
        word_errors++;
        if (word_errors <= 10)
          $display("ERROR: expected word %h match %b number %0d, got %h %b %0d",
                   want.word_value, want.crc_match, want.word_number,
                   word_value, crc_match, word_number);
      end
    end
  endtask

  // Track config, predict on each byte request, check each word request
  always @(posedge clk) begin
    if (rst) begin
      crc_cfg.crc_polynomial  = swcc_pkg::POLY_RESET;
      crc_cfg.crc_start_value = swcc_pkg::START_RESET;
      triple_pos  = PH_HIGH;
      high_data   = '0;
      low_data    = '0;
      crc_acc     = swcc_pkg::START_RESET;
      word_index  = '0;
      word_errors = 0;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == swcc_pkg::CFG_POLY) crc_cfg.crc_polynomial = cfg_data;
        else crc_cfg.crc_start_value = cfg_data;
      end
      if (in_valid && in_ready) predict_byte(rx_byte, response_start);
      if (out_valid && out_ready) check_word();
    end
    words_outstanding = expected_words.size();
  end

endmodule

>>> tb/sensor_word_crc_checker_top_test.sv
`timescale 1ns / 100ps
// Test top for the sensor word CRC checker: clock, reset, byte and config stimulus, verdict.
// Depends on swcc_pkg, sensor_word_crc_checker_top and swcc_word_checker.
module sensor_word_crc_checker_top_test;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = swcc_pkg::CFG_POLY;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        response_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] word_value;
  logic        crc_match;
  logic [2:0]  word_number;
  int          word_errors;
  int          words_outstanding;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  logic [7:0]  cur_poly = swcc_pkg::POLY_RESET;
  logic [7:0]  cur_init = swcc_pkg::START_RESET;

  // Config sets per random phase, extremes first
  logic [7:0]  poly_set [6] = '{8'h00, 8'hFF, 8'h07, 8'h00, 8'h31, 8'h9B};
  logic [7:0]  init_set [6] = '{8'h00, 8'hFF, 8'hA5, 8'h00, 8'hFF, 8'h00};

  sensor_word_crc_checker_top dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .rx_byte, .response_start,
    .out_valid, .out_ready, .word_value, .crc_match, .word_number
  );

  swcc_word_checker chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .rx_byte, .response_start,
    .out_valid, .out_ready, .word_value, .crc_match, .word_number,
    .word_errors, .words_outstanding
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the word channel in changing modes: open, coin flip, mostly closed
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(30, 150);
    end
    mode_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // CRC of a word under the settings the generator believes are active
  function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] v;
    v = cur_init;
    for (int k = 0; k < 2; k++) begin
      v = v ^ (k == 0 ? hi : lo);
      for (int b = 0; b < 8; b++)
        v = v[7] ? ((v << 1) ^ cur_poly) : (v << 1);
    end
    return v;
  endfunction

  // Issue one byte request; between bursts, often insert a random gap
  task automatic send_byte(input logic [7:0] data, input logic start);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    rx_byte        <= data;
    response_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send one triple, with a good or a random CRC byte
  task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input logic start,
                           input logic good);
    logic [7:0] crc;
    crc = good ? word_crc(hi, lo) : 8'($urandom);
    send_byte(hi, start);
    send_byte(lo, 1'b0);
    send_byte(crc, 1'b0);
  endtask

  // Hold off until every predicted word is delivered and the pipe settles
  task automatic drain();
    in_valid <= 1'b0;
    while (words_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx == swcc_pkg::CFG_POLY) cur_poly = value;
    else cur_init = value;
  endtask

  // Mostly well-formed responses, some cut short, some plain noise
  task automatic random_phase(input int target);
    int pick;
    int nwords;
    int first;
    first = 1;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (first || pick < 80) begin
        nwords = first ? 10 : (($urandom_range(0, 5) == 0) ? $urandom_range(8, 12)
                                                         : $urandom_range(1, 4));
        for (int w = 0; w < nwords; w++)
          send_word(8'($urandom), 8'($urandom),
                    (w == 0) && (first || $urandom_range(0, 6) != 0),
                    $urandom_range(0, 99) < 85);
        first = 0;
      end else if (pick < 90) begin
        send_byte(8'($urandom), 1'b1);
        if ($urandom_range(0, 1)) send_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    logic [7:0] held_crc;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: known word under the default settings, zero and full words
    send_byte(8'hBE, 1'b1);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h92, 1'b0);
    send_word(8'h00, 8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(word_crc(8'hFF, 8'hFF) ^ 8'h01, 1'b0);
    // Start mark after one byte, then after two: drop the partial triple
    send_byte(8'h12, 1'b0);
    send_word(8'h34, 8'h56, 1'b1, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_word(8'h01, 8'h02, 1'b1, 1'b1);
    // CRC byte at both extremes
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Start value changed inside a word: the word keeps its old start
    held_crc = word_crc(8'h11, 8'h22);
    send_byte(8'h11, 1'b1);
    drain();
    write_reg(swcc_pkg::CFG_START, 8'h00);
    send_byte(8'h22, 1'b0);
    send_byte(held_crc, 1'b0);
    // Polynomial changed inside a word: applies to the low byte
    held_crc = word_crc(8'h33, 8'h44);
    send_byte(8'h33, 1'b0);
    drain();
    write_reg(swcc_pkg::CFG_POLY, 8'h07);
    send_byte(8'h44, 1'b0);
    send_byte(held_crc, 1'b0);
    drain();

    // Random phases, one config set each
    poly_set[3] = 8'($urandom);
    init_set[3] = 8'($urandom);
    for (int p = 0; p < 6; p++) begin
      write_reg(swcc_pkg::CFG_POLY, poly_set[p]);
      write_reg(swcc_pkg::CFG_START, init_set[p]);
      random_phase(bytes_sent + 88);
      drain();
    end

    in_valid <= 1'b0;
    while (words_outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (word_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
